// ===== sv/keypad_scan_debounce_fifo_assert.svh =====
// Assertion macros for the keypad scanner modules; only kps_queue uses them.
// Depends on nothing; files that check their own logic include it.
`ifndef KEYPAD_SCAN_DEBOUNCE_FIFO_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_FIFO_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keypad scanner check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad scanner check failed");

`endif

// ===== sv/kps_pkg.sv =====
// Shared types, constants and the key picker for the keypad scanner.
// Depends on nothing; every module of the scanner imports it.
package kps_pkg;

	localparam int KEY_W  = 5;
	localparam int HOLD_W = 8;
	localparam int SNAP_W = 16;
	localparam int GRID_N = 4;

	localparam logic [KEY_W-1:0] NO_KEY = '0;

	typedef enum logic [1:0] {
		KIND_SCAN  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_INIT  = 2'd3
	} kps_kind_t;

	// Queue controls, one-hot or all low for a given cycle.
	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
	} kps_q_ctrl_t;

	// Entry written into or read out of the queue.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [HOLD_W-1:0] hold;
	} kps_entry_t;

	// Columns are scanned 0..3, rows 0..3 inside each column; the last closed
	// key in that order wins and is coded as row*4+column+1.
	function automatic logic [KEY_W-1:0] pick_key(input logic [SNAP_W-1:0] snap);
		logic [KEY_W-1:0] key;
		key = NO_KEY;
		for (int col = 0; col < GRID_N; col++) begin
			for (int row = 0; row < GRID_N; row++) begin
				if (snap[row*GRID_N + col]) begin
					key = KEY_W'(row*GRID_N + col + 1);
				end
			end
		end
		return key;
	endfunction

endpackage

// ===== sv/kps_debounce.sv =====
// Debounce and auto-repeat blocking for the keypad scanner, plus the hold counter.
// Depends on kps_pkg.
module kps_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      scan,
	input  logic [kps_pkg::KEY_W-1:0] key,
	output logic                      accept,
	output logic [kps_pkg::HOLD_W-1:0] hold
);
	import kps_pkg::*;

	logic [KEY_W-1:0]  prev_q;
	logic [KEY_W-1:0]  last_q;
	logic [HOLD_W-1:0] tick_q;

	assign hold   = tick_q + HOLD_W'(1);
	assign accept = scan && (key != NO_KEY) && (key == prev_q) && (key != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= NO_KEY;
			last_q <= NO_KEY;
			tick_q <= '0;
		end else if (scan) begin
			prev_q <= key;
			tick_q <= accept ? '0 : hold;
			if (key == NO_KEY) begin
				last_q <= NO_KEY;
			end else if (accept) begin
				last_q <= key;
			end
		end
	end

endmodule

// ===== sv/kps_queue.sv =====
// Key queue of the keypad scanner: entry storage and the write and read slots.
// Depends on kps_pkg and the shared assertion macros.
`include "keypad_scan_debounce_fifo_assert.svh"

module kps_queue #(
	parameter int QUEUE_SLOTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kps_pkg::kps_q_ctrl_t ctrl,
	input  kps_pkg::kps_entry_t  wr_entry,
	output logic                 rd_valid,
	output kps_pkg::kps_entry_t  rd_entry
);
	import kps_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
	localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(QUEUE_SLOTS);

	kps_entry_t       mem_q [QUEUE_SLOTS];
	logic [CNT_W-1:0] wr_slot_q;
	logic [CNT_W-1:0] rd_slot_q;
	logic [CNT_W-1:0] wr_base;
	logic [CNT_W-1:0] rd_base;
	logic             same;
	logic             room;

	// When every stored entry has been read, a new key restarts both slots at zero.
	assign same    = (wr_slot_q == rd_slot_q);
	assign wr_base = same ? '0 : wr_slot_q;
	assign rd_base = same ? '0 : rd_slot_q;
	assign room    = (wr_base < SLOTS_C);

	assign rd_valid = (rd_slot_q < wr_slot_q);
	always_comb begin
		rd_entry = '0;
		if (rd_valid) begin
			rd_entry = mem_q[rd_slot_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
		end else if (ctrl.flush) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
		end else if (ctrl.push) begin
			rd_slot_q <= rd_base;
			wr_slot_q <= room ? wr_base + CNT_W'(1) : wr_base;
		end else if (ctrl.pop && rd_valid) begin
			rd_slot_q <= rd_slot_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && room) begin
			mem_q[wr_base[IDX_W-1:0]] <= wr_entry;
		end
	end

	`KPS_ASSERT_NOW(a_wr_bound, clk, arst_n, 1'b1, wr_slot_q <= SLOTS_C)
	`KPS_ASSERT_NOW(a_rd_behind, clk, arst_n, 1'b1, rd_slot_q <= wr_slot_q)
	`KPS_ASSERT_NEXT(a_flush_empty, clk, arst_n, ctrl.flush, wr_slot_q == '0 && rd_slot_q == '0)

endmodule

// ===== sv/keypad_scan_debounce_fifo.sv =====
// A word accepted into the input register has its result word written into the output
// register as soon as the result register is free to take it.
// Throughput: one word per cycle while out_stall is low; the input register and the result
// register each hold one word, and every kind of word is finished by one pass of short logic.
// Reset (arst_n low, asynchronous): both registers empty, queue slots, hold counter
// and the debounce memories cleared; the stored queue entries are not cleared.
module keypad_scan_debounce_fifo #(
	parameter int QUEUE_SLOTS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [kps_pkg::SNAP_W-1:0]  pressed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        data_valid,
	output logic [kps_pkg::KEY_W-1:0]   key_code,
	output logic [kps_pkg::HOLD_W-1:0]  hold_ticks,
	output logic                        key_accepted
);
	import kps_pkg::*;

	// Input register. A word waits here until the result register can take its
	// result; that is the moment its effect on the block state is committed.
	logic              valid_s1;
	kps_kind_t         kind_s1;
	logic [SNAP_W-1:0] pressed_s1;

	// Result register.
	logic              valid_s2;
	logic              data_valid_s2;
	logic [KEY_W-1:0]  key_code_s2;
	logic [HOLD_W-1:0] hold_ticks_s2;
	logic              key_accepted_s2;

	logic              advance;
	logic              fire;
	logic [KEY_W-1:0]  picked;
	logic              accept;
	logic [HOLD_W-1:0] hold;
	kps_q_ctrl_t       q_ctrl;
	kps_entry_t        wr_entry;
	logic              rd_valid;
	kps_entry_t        rd_entry;

	// The result register frees up when it is empty or its word is taken now.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1    <= kps_kind_t'(kind);
			pressed_s1 <= pressed;
		end
	end

	// The key picker is a fixed priority encoder over the snapshot.
	assign picked = pick_key(pressed_s1);

	kps_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (fire && (kind_s1 == KIND_SCAN)),
		.key    (picked),
		.accept (accept),
		.hold   (hold)
	);

	// Clear and init both empty the queue; only reads and scans touch it otherwise.
	always_comb begin
		q_ctrl = '0;
		if (fire) begin
			case (kind_s1)
				KIND_SCAN:  q_ctrl.push  = accept;
				KIND_READ:  q_ctrl.pop   = 1'b1;
				KIND_CLEAR: q_ctrl.flush = 1'b1;
				KIND_INIT:  q_ctrl.flush = 1'b1;
				default:    q_ctrl = '0;
			endcase
		end
	end

	assign wr_entry.key  = picked;
	assign wr_entry.hold = hold;

	kps_queue #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.wr_entry (wr_entry),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Every field is zero unless the kind of word gives it a meaning.
	always_ff @(posedge clk) begin
		if (fire) begin
			data_valid_s2   <= (kind_s1 == KIND_READ) && rd_valid;
			key_code_s2     <= (kind_s1 == KIND_READ) ? rd_entry.key : NO_KEY;
			hold_ticks_s2   <= (kind_s1 == KIND_READ) ? rd_entry.hold : '0;
			key_accepted_s2 <= (kind_s1 == KIND_SCAN) && accept;
		end
	end

	assign out_valid    = valid_s2;
	assign data_valid   = data_valid_s2;
	assign key_code     = key_code_s2;
	assign hold_ticks   = hold_ticks_s2;
	assign key_accepted = key_accepted_s2;

endmodule
